FILE: hdl/lbct_pkg.sv
// Package for the LRU block cache tracker.
// Holds the token types that travel down the cell chain and shared constants.
// No dependencies.
package lbct_pkg;

    localparam int unsigned BLOCK_W         = 32;
    localparam int unsigned COUNT_W         = 32;
    localparam int unsigned CACHE_ENTRIES_DEF = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic               done;
        logic [BLOCK_W-1:0] blk;
        logic               carry_valid;
        logic [BLOCK_W-1:0] carry_tag;
    } token_data_t;

    typedef struct packed {
        logic        valid;
        token_data_t data;
    } token_t;

endpackage

FILE: hdl/lbct_cell.sv
// One cell of the LRU stack: holds one tag and its valid bit.
// Swaps its entry with the carried one and stops the carry on a tag match.
// Depends on lbct_pkg.
module lbct_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  lbct_pkg::token_t tok_in,
    output lbct_pkg::token_t tok_out
);

    logic                         entry_valid_reg;
    logic                         entry_valid_next;
    logic [lbct_pkg::BLOCK_W-1:0] tag_reg;
    logic [lbct_pkg::BLOCK_W-1:0] tag_next;
    logic                         tok_valid_reg;
    lbct_pkg::token_data_t        tok_data_reg;
    lbct_pkg::token_data_t        tok_data_next;
    logic                         active;
    logic                         match;

    always_comb begin
        active           = tok_in.valid && !tok_in.data.done;
        match            = active && entry_valid_reg && (tag_reg == tok_in.data.blk);
        tag_next         = active ? tok_in.data.carry_tag : tag_reg;
        entry_valid_next = active ? tok_in.data.carry_valid : entry_valid_reg;
        tok_data_next    = tok_in.data;
        if (match) begin
            tok_data_next.done = 1'b1;
        end else if (active) begin
            tok_data_next.carry_tag   = tag_reg;
            tok_data_next.carry_valid = entry_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
            tok_valid_reg   <= 1'b0;
        end else if (advance) begin
            entry_valid_reg <= entry_valid_next;
            tok_valid_reg   <= tok_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tag_reg      <= tag_next;
            tok_data_reg <= tok_data_next;
        end
    end

    assign tok_out.valid = tok_valid_reg;
    assign tok_out.data  = tok_data_reg;

endmodule

FILE: hdl/lbct_result.sv
// Result stage: turns the token leaving the chain into a result transaction.
// Keeps the saturating hit and miss counters and the output register.
// Depends on lbct_pkg.
module lbct_result (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lbct_pkg::token_t             tok_in,
    output logic                         advance,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic                         m_evicted_valid,
    output logic [lbct_pkg::BLOCK_W-1:0] m_evicted_block,
    output logic [lbct_pkg::COUNT_W-1:0] m_hit_count,
    output logic [lbct_pkg::COUNT_W-1:0] m_miss_count
);

    logic                         valid_reg;
    logic                         hit_reg;
    logic                         ev_valid_reg;
    logic                         ev_valid_next;
    logic [lbct_pkg::BLOCK_W-1:0] ev_block_reg;
    logic [lbct_pkg::BLOCK_W-1:0] ev_block_next;
    logic [lbct_pkg::COUNT_W-1:0] hit_cnt_reg;
    logic [lbct_pkg::COUNT_W-1:0] hit_cnt_next;
    logic [lbct_pkg::COUNT_W-1:0] miss_cnt_reg;
    logic [lbct_pkg::COUNT_W-1:0] miss_cnt_next;
    logic                         load;

    always_comb begin
        advance       = !valid_reg || m_ready;
        load          = advance && tok_in.valid;
        ev_valid_next = !tok_in.data.done && tok_in.data.carry_valid;
        ev_block_next = ev_valid_next ? tok_in.data.carry_tag : '0;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (tok_in.data.done) begin
            if (hit_cnt_reg != lbct_pkg::COUNT_MAX) begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
        end else begin
            if (miss_cnt_reg != lbct_pkg::COUNT_MAX) begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else begin
            if (advance) begin
                valid_reg <= tok_in.valid;
            end
            if (load) begin
                hit_cnt_reg  <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hit_reg      <= tok_in.data.done;
            ev_valid_reg <= ev_valid_next;
            ev_block_reg <= ev_block_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_hit           = hit_reg;
    assign m_evicted_valid = ev_valid_reg;
    assign m_evicted_block = ev_block_reg;
    assign m_hit_count     = hit_cnt_reg;
    assign m_miss_count    = miss_cnt_reg;

endmodule

FILE: hdl/lru_block_cache_tracker.sv
// Fully associative LRU block cache tracker, top level.
// Depends on lbct_pkg, lbct_cell and lbct_result.
//
// Usage:
//   Input channel s_valid/s_ready carries one block number per transaction.
//   Output channel m_valid/m_ready returns one result per transaction, in order:
//   hit flag, evicted block and its valid flag, and the saturating hit and
//   miss counters including this access.
//   The cache is a stack of CACHE_ENTRIES cells, most recently used on top.
//   Each transaction enters the top cell and moves one cell per cycle while the
//   chain is not stalled, swapping entries as it goes until it meets its own tag
//   or falls off the bottom; it then passes the result register to reach m_valid.
//   Throughput: one transaction per cycle while not stalled; later transactions
//   follow one cell behind earlier ones, so each sees the stack as left by all before it.
//   Reset: all entries invalid, counters zero, chain and output empty.
//   Stall: while m_valid is high and m_ready low the whole chain freezes and
//   s_ready drops; nothing is lost or repeated.
module lru_block_cache_tracker #(
    parameter int unsigned CACHE_ENTRIES = lbct_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lbct_pkg::BLOCK_W-1:0] s_block_number,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic                         m_evicted_valid,
    output logic [lbct_pkg::BLOCK_W-1:0] m_evicted_block,
    output logic [lbct_pkg::COUNT_W-1:0] m_hit_count,
    output logic [lbct_pkg::COUNT_W-1:0] m_miss_count
);

    lbct_pkg::token_t tok [0:CACHE_ENTRIES];
    logic             advance;

    assign s_ready                = advance;
    assign tok[0].valid           = s_valid;
    assign tok[0].data.done       = 1'b0;
    assign tok[0].data.blk        = s_block_number;
    assign tok[0].data.carry_valid = 1'b1;
    assign tok[0].data.carry_tag  = s_block_number;

    for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
        lbct_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    lbct_result u_result (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tok_in          (tok[CACHE_ENTRIES]),
        .advance         (advance),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_block (m_evicted_block),
        .m_hit_count     (m_hit_count),
        .m_miss_count    (m_miss_count)
    );

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted_valid))
        else $error("hit reported together with an eviction");

    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted_valid) |-> (m_evicted_block == '0))
        else $error("evicted block nonzero without a valid eviction");

    a_tail_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tok[CACHE_ENTRIES].valid) |=>
            (m_valid && (m_hit == $past(tok[CACHE_ENTRIES].data.done))))
        else $error("chain tail not carried into result register");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tok[CACHE_ENTRIES].valid && tok[CACHE_ENTRIES].data.done
            && (m_hit_count != lbct_pkg::COUNT_MAX)) |=>
            (m_hit_count == $past(m_hit_count) + 1'b1))
        else $error("hit counter did not advance on a hit");

endmodule
